FILE: rtl/swm_pkg.sv
// Package for the sliding window maximum core: sizes, candidate cell types and control codes.
`default_nettype none

package swm_pkg;

    localparam int CAND_SLOTS = 64;
    localparam int SAMPLE_W   = 32;
    localparam int WSIZE_W    = 7;
    // Ages stay at most CAND_SLOTS + 1 between cleanups.
    localparam int AGE_W      = $clog2(CAND_SLOTS + 2);
    localparam int FILL_W     = $clog2(CAND_SLOTS + 1);
    localparam int CMP_W      = (AGE_W > WSIZE_W) ? AGE_W : WSIZE_W;

    typedef struct packed {
        logic                valid;
        logic [AGE_W-1:0]    age;
        logic [SAMPLE_W-1:0] value;
    } cand_t;

    typedef struct packed {
        logic                step;
        logic                pop;
        logic                restart;
        logic [SAMPLE_W-1:0] sample;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_CLEAN = 2'b10
    } swm_state_t;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One candidate cell of the monotonic deque chain.
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       prev_kept,
    input  wire cand_t      right_cur,
    input  wire cand_t      right_post,
    output cand_t           cur,
    output cand_t           post,
    output logic            kept
);

    logic                valid_reg;
    logic                valid_next;
    logic [AGE_W-1:0]    age_reg;
    logic [AGE_W-1:0]    age_next;
    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                appended;
    cand_t               sel;

    assign cur.valid = valid_reg;
    assign cur.age   = age_reg;
    assign cur.value = value_reg;

    // A candidate survives the new sample only if it is strictly larger.
    assign kept     = !ctrl.restart && valid_reg
                      && ($signed(value_reg) > $signed(ctrl.sample));
    assign appended = prev_kept && !kept;

    always_comb
    begin
        post.valid = kept || appended;
        post.value = kept ? value_reg : ctrl.sample;
        post.age   = kept ? (age_reg + AGE_W'(1)) : AGE_W'(1);
    end

    always_comb
    begin
        if (ctrl.step)
        begin
            sel = ctrl.pop ? right_post : post;
        end
        else if (ctrl.pop)
        begin
            sel = right_cur;
        end
        else
        begin
            sel = cur;
        end
        valid_next = sel.valid;
        age_next   = sel.age;
        value_next = sel.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg   <= age_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_max_core.sv
// Sliding window maximum: a chain of candidate cells kept as a decreasing deque.
// A sample's result is loaded into the output register at the edge that accepts it, once the
// window has filled and unless the sample starts a cleanup. Throughput is one sample per cycle
// while at most one candidate expires per sample and the output register is free.
// After the window shrinks, a sample that expires more candidates than the head starts a cleanup
// that drops the further candidates and then loads its result; no sample is taken meanwhile.
// Reset empties the chain, zeroes the fill count and sets the window size to 1.
`default_nettype none

module sliding_window_max_core
    import swm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] s_axis_tdata,  // [31:0] sample
    input  wire logic                s_axis_tuser,  // [0] restart
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [SAMPLE_W-1:0]      m_axis_tdata,  // [31:0] maximum of the window
    input  wire logic                cfg_we,
    input  wire logic [WSIZE_W-1:0]  cfg_wdata
);

    swm_state_t          state_reg;
    swm_state_t          state_next;
    logic [WSIZE_W-1:0]  window_size_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                pend_emit_reg;
    logic                pend_emit_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic [SAMPLE_W-1:0] out_data_next;

    logic [CMP_W-1:0]    win_eff;
    logic [CMP_W-1:0]    ws_ext;
    logic                slot_free;
    logic                accept;
    logic                pop_step;
    logic                pop_clean;
    logic                after_exp;
    logic                fill_ok;
    cand_t               head_after;
    cell_ctrl_t          ctrl;

    cand_t               cell_cur  [0:CAND_SLOTS];
    cand_t               cell_post [0:CAND_SLOTS];
    logic                kept_chain [0:CAND_SLOTS];

    assign ws_ext = CMP_W'(window_size_reg);

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = CMP_W'(1);
        end
        else if (ws_ext > CMP_W'(CAND_SLOTS))
        begin
            win_eff = CMP_W'(CAND_SLOTS);
        end
        else
        begin
            win_eff = ws_ext;
        end
    end

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Stored ages are the age at the coming sample; after a step they are one ahead.
    // A head that the new sample outranks is already dropped by the compare, so no shift.
    assign pop_step  = !s_axis_tuser && cell_cur[0].valid
                       && (CMP_W'(cell_cur[0].age) >= win_eff) && kept_chain[1];
    assign pop_clean = cell_cur[0].valid && (CMP_W'(cell_cur[0].age) > win_eff);

    always_comb
    begin
        ctrl.step    = accept;
        ctrl.pop     = accept ? pop_step : ((state_reg == ST_CLEAN) && pop_clean);
        ctrl.restart = accept && s_axis_tuser;
        ctrl.sample  = s_axis_tdata;
    end

    // The slot past the last cell only ever receives the new sample.
    assign kept_chain[0]               = 1'b1;
    assign cell_cur[CAND_SLOTS].valid  = 1'b0;
    assign cell_cur[CAND_SLOTS].age    = '0;
    assign cell_cur[CAND_SLOTS].value  = '0;
    assign cell_post[CAND_SLOTS].valid = kept_chain[CAND_SLOTS];
    assign cell_post[CAND_SLOTS].age   = AGE_W'(1);
    assign cell_post[CAND_SLOTS].value = s_axis_tdata;

    for (genvar i = 0; i < CAND_SLOTS; i++)
    begin : g_cell
        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_kept  (kept_chain[i]),
            .right_cur  (cell_cur[i+1]),
            .right_post (cell_post[i+1]),
            .cur        (cell_cur[i]),
            .post       (cell_post[i]),
            .kept       (kept_chain[i+1])
        );
    end

    assign head_after = pop_step ? cell_post[1] : cell_post[0];
    assign after_exp  = head_after.valid && (CMP_W'(head_after.age) > win_eff);

    always_comb
    begin
        if (s_axis_tuser)
        begin
            fill_next = FILL_W'(1);
        end
        else if (fill_reg == FILL_W'(CAND_SLOTS))
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    assign fill_ok = CMP_W'(fill_next) >= win_eff;

    always_comb
    begin
        state_next     = state_reg;
        pend_emit_next = pend_emit_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (after_exp)
                    begin
                        state_next     = ST_CLEAN;
                        pend_emit_next = fill_ok;
                    end
                    else if (fill_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = head_after.value;
                    end
                end
            end
            ST_CLEAN:
            begin
                if (!pop_clean)
                begin
                    if (!pend_emit_reg)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (slot_free)
                    begin
                        state_next     = ST_RUN;
                        pend_emit_next = 1'b0;
                        out_valid_next = 1'b1;
                        out_data_next  = cell_cur[0].value;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            window_size_reg <= WSIZE_W'(1);
            fill_reg        <= '0;
            pend_emit_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_emit_reg <= pend_emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_sliding_window_max_core.sv
// Self-checking testbench for the sliding window maximum core with a scoreboard class.
`timescale 1ns / 100ps

module tb_sliding_window_max_core
    import swm_pkg::*;
();

    typedef bit signed [SAMPLE_W-1:0] sample_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 78;

    // Tracks the candidate deque and the expected maxima of the stream.
    class peak_tracker;
        bit [WSIZE_W-1:0] window_reg;
        sample_t          cand_val[$];
        bit [31:0]        cand_pos[$];
        bit [31:0]        next_pos;
        int unsigned      filled;
        sample_t          pending_max[$];
        int unsigned      fault_count;
        int unsigned      sample_count;
        int unsigned      result_count;

        function new();
            window_reg = 1;
            next_pos = 0;
            filled = 0;
            fault_count = 0;
            sample_count = 0;
            result_count = 0;
        endfunction

        function int unsigned span();
            if (window_reg == 0)
                return 1;
            if (window_reg > CAND_SLOTS)
                return CAND_SLOTS;
            return window_reg;
        endfunction

        function void take_sample(sample_t smp, bit restart);
            int unsigned w;
            bit [31:0]   age;
            w = span();
            sample_count++;
            if (restart)
            begin
                cand_val.delete();
                cand_pos.delete();
                next_pos = 0;
                filled = 0;
            end
            while (cand_pos.size() > 0)
            begin
                age = next_pos - cand_pos[0];
                if (age < w)
                    break;
                cand_val.delete(0);
                cand_pos.delete(0);
            end
            while (cand_val.size() > 0 && smp >= cand_val[$])
            begin
                cand_val.delete(cand_val.size() - 1);
                cand_pos.delete(cand_pos.size() - 1);
            end
            cand_val.insert(cand_val.size(), smp);
            cand_pos.insert(cand_pos.size(), next_pos);
            next_pos++;
            if (filled < CAND_SLOTS)
                filled++;
            if (filled >= w)
                pending_max.insert(pending_max.size(), cand_val[0]);
        endfunction

        function void check_result(sample_t got);
            sample_t want;
            result_count++;
            if (pending_max.size() == 0)
            begin
                if (fault_count < 10)
                    $display("Window maximum %0d arrived with no result expected", got);
                fault_count++;
                return;
            end
            want = pending_max[0];
            pending_max.delete(0);
            if (got !== want)
            begin
                if (fault_count < 10)
                    $display("Window maximum mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                             want, want, got, got);
                fault_count++;
            end
        endfunction

        function void close();
            if (pending_max.size() != 0)
            begin
                $display("%0d expected window maxima never arrived", pending_max.size());
                fault_count += pending_max.size();
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;   // [31:0] sample
    logic                s_axis_tuser = 1'b0; // [0] restart
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;        // [31:0] maximum of the window
    logic                cfg_we = 1'b0;
    logic [WSIZE_W-1:0]  cfg_wdata = '0;

    peak_tracker       sb;
    bit                calm = 1'b0;
    int unsigned       hold_asked = 0;
    int unsigned       hold_done = 0;
    int unsigned       cycle_count = 0;
    int unsigned       window_writes = 0;

    sliding_window_max_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic restart);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_sample(smp, restart);
    endtask

    // Stops offering requests until every expected maximum has been taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_max.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [WSIZE_W-1:0] w);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        sb.window_reg = w;
        window_writes++;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(input int style, input int idx);
        int pick;
        if ($urandom_range(99) < 5)
        begin
            pick = $urandom_range(3);
            case (pick)
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        case (style)
            // Narrow range gives many equal values and frequent evictions.
            1: return int'($urandom_range(16)) - 8;
            // Mostly falling ramp keeps the deque deep.
            2: return 2000000000 - idx * 4096
                      + (($urandom_range(15) == 0) ? int'($urandom_range(8192)) : 0);
            3: return -1000000 + idx * 7 - int'($urandom_range(3));
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int unsigned phase_window[PHASES];
        int          phase_style[PHASES];
        int          restart_pct;

        phase_window = '{4, 64, 1, 9, 127, 2, 31, 0, 17, 64};
        phase_style  = '{1, 2, 0, 1, 2, 0, 3, 1, 0, 2};
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of one after reset, field extremes and a restart.
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);

        // Short window: fill-up, equal values evicting, extremes.
        set_window(WSIZE_W'(3));
        send_sample(5, 1'b1);
        send_sample(3, 1'b0);
        send_sample(4, 1'b0);
        send_sample(4, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);

        // A zero window size behaves as a window of one.
        set_window(WSIZE_W'(0));
        send_sample(-2, 1'b0);
        send_sample(-3, 1'b0);

        // Oversized window, a sequence shorter than the window, then resizes mid-stream.
        set_window(WSIZE_W'(127));
        send_sample(9, 1'b1);
        send_sample(8, 1'b0);
        send_sample(7, 1'b0);
        set_window(WSIZE_W'(4));
        send_sample(6, 1'b0);
        send_sample(1, 1'b0);
        // Shrinking to one expires several candidates at once.
        set_window(WSIZE_W'(1));
        send_sample(-5, 1'b0);
        // After enlarging, only the retained sample is covered.
        set_window(WSIZE_W'(5));
        send_sample(-6, 1'b0);
        send_sample(100, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_window(WSIZE_W'(phase_window[p]));
            calm = (p == 3);
            restart_pct = (p == 5) ? 15 : 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 66)
                    hold_asked++;
                if (p == 6 && i == 40)
                    settle();
                send_sample(draw_sample(phase_style[p], i),
                            $urandom_range(99) < restart_pct);
            end
        end
        calm = 1'b0;

        settle();
        sb.close();
        $display("Run took %0d samples and checked %0d window maxima over %0d window settings,",
                 sb.sample_count, sb.result_count, window_writes);
        $display("with sizes 0 through 127, restarts, resizes and a long output stall.");
        if (sb.fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sliding_window_max_core.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_max_core.sv
tb/tb_sliding_window_max_core.sv
